### rtl/core/piecewise_linear_trajectory_interp_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory interpolator
// Shared property shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TRAJECTORY_INTERP_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_TRAJECTORY_INTERP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PLTI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define PLTI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Constants shared by the trajectory interpolator and its checker.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COORD_W    = 48;
  localparam int unsigned ROW_W      = 6 * COORD_W;
  localparam int unsigned ALPHA_W    = 24;
  localparam int unsigned ONE_SECOND = 256;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

endpackage

### rtl/core/piecewise_linear_trajectory_interp_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_trajectory_interp_core
// Trajectory point table with clamped piecewise linear position lookup.
// ----------------------------------------------------------------------------
// Usage:
//  - Drive kind_i and the payload with start_i high; the item is taken on the
//    edge where busy_o is low. Clear and append finish in that edge.
//  - A query raises busy_o until its result; done_o strobes for one cycle
//    with pos_*, vel_* and status_o valid. The receiver cannot stall.
//  - Sequence: an empty table strobes done_o in the cycle right after the
//    accepting edge. Otherwise each of the (up to two) evaluations runs a
//    setup state, a binary search with a search and a compare state per
//    halving step over the time memory (10 steps at 1024 points) plus an
//    exit state, two row reads, a restoring divider for the 24 alpha bits,
//    a multiply-accumulate of low, high and accumulate states for each of
//    the 3 components and a finishing state; a clamped evaluation runs the
//    setup, clamp and finishing states.
//  - One item at a time: the time and coordinate memories have a single
//    read port shared by the search and the row fetch.
//  - cfg_we_i writes use_ecef (reset 1) from cfg_wdata_i; write it only
//    while busy_o is low.
//  - Reset clears the point count and the drop flag; memories hold no reset.
// ----------------------------------------------------------------------------
module piecewise_linear_trajectory_interp_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic [1:0]                          kind_i,
  input  logic [plti_pkg::TIME_W-1:0]         point_time_i,
  input  logic signed [plti_pkg::COORD_W-1:0] ecef_x_i,
  input  logic signed [plti_pkg::COORD_W-1:0] ecef_y_i,
  input  logic signed [plti_pkg::COORD_W-1:0] ecef_z_i,
  input  logic signed [plti_pkg::COORD_W-1:0] latitude_i,
  input  logic signed [plti_pkg::COORD_W-1:0] longitude_i,
  input  logic signed [plti_pkg::COORD_W-1:0] altitude_i,
  input  logic [plti_pkg::TIME_W-1:0]         query_time_i,
  output logic                                done_o,
  output logic signed [plti_pkg::COORD_W-1:0] pos_first_o,
  output logic signed [plti_pkg::COORD_W-1:0] pos_second_o,
  output logic signed [plti_pkg::COORD_W-1:0] pos_third_o,
  output logic signed [plti_pkg::COORD_W-1:0] vel_first_o,
  output logic signed [plti_pkg::COORD_W-1:0] vel_second_o,
  output logic signed [plti_pkg::COORD_W-1:0] vel_third_o,
  output logic [1:0]                          status_o
);
  import plti_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SETUP = 13'b0000000000010,
    S_SRCH  = 13'b0000000000100,
    S_SCMP  = 13'b0000000001000,
    S_T1    = 13'b0000000010000,
    S_T2    = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_MLO   = 13'b0000010000000,
    S_MHI   = 13'b0000100000000,
    S_ACC   = 13'b0001000000000,
    S_CLAMP = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  // Control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               dropped_q, dropped_d;
  logic               use_ecef_q;
  logic               eval_q, eval_d;
  logic [1:0]         comp_q, comp_d;
  logic [4:0]         step_q, step_d;

  // Payload state
  logic [TIME_W-1:0]         first_q, first_d, last_q, last_d, qt_q, qt_d;
  logic [TIME_W:0]           t_q, t_d;
  logic [IDX_W-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [TIME_W-1:0]         t1_q, t1_d, dvs_q, dvs_d;
  logic [TIME_W:0]           rem_q, rem_d;
  logic [ALPHA_W:0]          alpha_q, alpha_d;
  logic [49:0]               pl_q, pl_d;
  logic signed [49:0]        ph_q, ph_d;
  logic signed [COORD_W-1:0] p1_q [3], p1_d [3];
  logic signed [COORD_W-1:0] p2_q [3], p2_d [3];
  logic signed [COORD_W-1:0] res_q [3], res_d [3];
  logic signed [COORD_W-1:0] pos_q [3], pos_d [3];
  logic signed [COORD_W-1:0] vel_q [3], vel_d [3];
  logic [1:0]                status_q, status_d;

  // Memories: one row per point, one shared read address
  logic [TIME_W-1:0] tmem [MAX_POINTS];
  logic [ROW_W-1:0]  cmem [MAX_POINTS];
  logic [TIME_W-1:0] t_rdata_q;
  logic [ROW_W-1:0]  c_rdata_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_row;

  logic              accept;
  logic [IDX_W-1:0]  last_idx, mid;
  logic [TIME_W:0]   rem2;
  logic signed [48:0] diff;
  logic signed [73:0] full;
  logic signed [COORD_W:0] vdiff;
  logic [2:0]        sel_base;

  assign accept   = start_i && (state_q == S_IDLE);
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign rem2     = {rem_q[TIME_W-1:0], 1'b0};
  assign diff     = {p2_q[comp_q][COORD_W-1], p2_q[comp_q]}
                  - {p1_q[comp_q][COORD_W-1], p1_q[comp_q]};
  assign full     = ($signed({{24{ph_q[49]}}, ph_q}) <<< 25) + $signed({24'b0, pl_q});
  assign sel_base = use_ecef_q ? 3'd0 : 3'd3;
  assign wr_row   = {altitude_i, longitude_i, latitude_i, ecef_z_i, ecef_y_i, ecef_x_i};
  assign wr_en    = accept && (kind_i == KIND_APPEND) && (count_q < CNT_W'(MAX_POINTS))
                    && !((count_q != '0) && (point_time_i < last_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tmem[count_q[IDX_W-1:0]] <= point_time_i;
      cmem[count_q[IDX_W-1:0]] <= wr_row;
    end
    t_rdata_q <= tmem[rd_addr];
    c_rdata_q <= cmem[rd_addr];
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    eval_d    = eval_q;
    comp_d    = comp_q;
    step_d    = step_q;
    first_d   = first_q;
    last_d    = last_q;
    qt_d      = qt_q;
    t_d       = t_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    t1_d      = t1_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    alpha_d   = alpha_q;
    pl_d      = pl_q;
    ph_d      = ph_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    res_d     = res_q;
    pos_d     = pos_q;
    vel_d     = vel_q;
    status_d  = status_q;
    rd_addr   = '0;
    vdiff     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_CLEAR: begin
              count_d   = '0;
              dropped_d = 1'b0;
            end
            KIND_APPEND: begin
              if (wr_en) begin
                if (count_q == '0) first_d = point_time_i;
                last_d  = point_time_i;
                count_d = count_q + CNT_W'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            KIND_QUERY: begin
              qt_d   = query_time_i;
              t_d    = {1'b0, query_time_i};
              eval_d = 1'b0;
              if (count_q == '0) begin
                // empty table: answer zeros at once
                for (int k = 0; k < 3; k++) begin
                  pos_d[k] = '0;
                  vel_d[k] = '0;
                end
                status_d = STATUS_EMPTY;
                state_d  = S_OUT;
              end else begin
                status_d = dropped_q ? STATUS_DROPPED : STATUS_OK;
                state_d  = S_SETUP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        // clamp at or before the first or at or past the last point, else search
        if (t_q <= {1'b0, first_q}) begin
          rd_addr = '0;
          state_d = S_CLAMP;
        end else if (t_q >= {1'b0, last_q}) begin
          rd_addr = last_idx;
          state_d = S_CLAMP;
        end else begin
          lo_d    = IDX_W'(1);
          hi_d    = last_idx;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          rd_addr = mid;
          mid_d   = mid;
          state_d = S_SCMP;
        end else begin
          rd_addr = lo_q - IDX_W'(1);
          state_d = S_T1;
        end
      end
      S_SCMP: begin
        if ({1'b0, t_rdata_q} < t_q) lo_d = mid_q + IDX_W'(1);
        else                         hi_d = mid_q;
        state_d = S_SRCH;
      end
      S_T1: begin
        // capture the lower bracket, fetch the upper one
        t1_d = t_rdata_q;
        for (int k = 0; k < 3; k++)
          p1_d[k] = c_rdata_q[(int'(sel_base) + k) * COORD_W +: COORD_W];
        rd_addr = lo_q;
        state_d = S_T2;
      end
      S_T2: begin
        dvs_d = t_rdata_q - t1_q;
        // a query on the upper point gives a full-scale alpha of one
        if (t_q[TIME_W-1:0] == t_rdata_q) begin
          alpha_d = (ALPHA_W + 1)'(1);
          rem_d   = '0;
        end else begin
          alpha_d = '0;
          rem_d   = {1'b0, t_q[TIME_W-1:0] - t1_q};
        end
        for (int k = 0; k < 3; k++)
          p2_d[k] = c_rdata_q[(int'(sel_base) + k) * COORD_W +: COORD_W];
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (rem2 >= {1'b0, dvs_q}) begin
          rem_d   = rem2 - {1'b0, dvs_q};
          alpha_d = {alpha_q[ALPHA_W-1:0], 1'b1};
        end else begin
          rem_d   = rem2;
          alpha_d = {alpha_q[ALPHA_W-1:0], 1'b0};
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'(ALPHA_W - 1)) begin
          comp_d  = '0;
          state_d = S_MLO;
        end
      end
      S_MLO: begin
        pl_d    = {25'b0, alpha_q} * {25'b0, diff[24:0]};
        state_d = S_MHI;
      end
      S_MHI: begin
        ph_d    = $signed({24'b0, alpha_q}) * $signed({{26{diff[48]}}, diff[48:25]});
        state_d = S_ACC;
      end
      S_ACC: begin
        res_d[comp_q] = p1_q[comp_q] + full[24 +: COORD_W];
        comp_d = comp_q + 2'd1;
        state_d = (comp_q == 2'd2) ? S_FIN : S_MLO;
      end
      S_CLAMP: begin
        for (int k = 0; k < 3; k++)
          res_d[k] = c_rdata_q[(int'(sel_base) + k) * COORD_W +: COORD_W];
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!eval_q) begin
          pos_d = res_q;
          if (count_q >= CNT_W'(2)) begin
            // second evaluation one second later, no wrap
            t_d     = {1'b0, qt_q} + (TIME_W + 1)'(ONE_SECOND);
            eval_d  = 1'b1;
            state_d = S_SETUP;
          end else begin
            for (int k = 0; k < 3; k++) vel_d[k] = '0;
            state_d = S_OUT;
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            vdiff = {res_q[k][COORD_W-1], res_q[k]} - {pos_q[k][COORD_W-1], pos_q[k]};
            if (vdiff[COORD_W] != vdiff[COORD_W-1])
              vel_d[k] = vdiff[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}};
            else
              vel_d[k] = vdiff[COORD_W-1:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      use_ecef_q <= 1'b1;
      eval_q     <= 1'b0;
      comp_q     <= '0;
      step_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      eval_q    <= eval_d;
      comp_q    <= comp_d;
      step_q    <= step_d;
      if (cfg_we_i) use_ecef_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    last_q   <= last_d;
    qt_q     <= qt_d;
    t_q      <= t_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    t1_q     <= t1_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    alpha_q  <= alpha_d;
    pl_q     <= pl_d;
    ph_q     <= ph_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    res_q    <= res_d;
    pos_q    <= pos_d;
    vel_q    <= vel_d;
    status_q <= status_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_OUT);
  assign pos_first_o  = pos_q[0];
  assign pos_second_o = pos_q[1];
  assign pos_third_o  = pos_q[2];
  assign vel_first_o  = vel_q[0];
  assign vel_second_o = vel_q[1];
  assign vel_third_o  = vel_q[2];
  assign status_o     = status_q;

endmodule

### rtl/core/plti_checker.sv
// ----------------------------------------------------------------------------
// plti_checker
// Port-level checks on the trajectory interpolator, bound into the core module.
// ----------------------------------------------------------------------------
`include "piecewise_linear_trajectory_interp_core_macros.svh"

module plti_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic [1:0]                          kind_i,
  input logic                                done_o,
  input logic signed [plti_pkg::COORD_W-1:0] pos_first_o,
  input logic signed [plti_pkg::COORD_W-1:0] vel_first_o,
  input logic [1:0]                          status_o
);
  import plti_pkg::*;

  // a query holds the block busy on the next cycle
  `PLTI_ASSERT_NXT(a_query_busy, clk_i, rst_ni, start_i && !busy_o && (kind_i == KIND_QUERY), busy_o)
  // clear, append and the spare kind never produce a result
  `PLTI_ASSERT_NXT(a_no_result, clk_i, rst_ni, start_i && !busy_o && (kind_i != KIND_QUERY), !done_o)
  // an empty table answers zeros in the first position and velocity
  `PLTI_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, done_o && (status_o == STATUS_EMPTY), (pos_first_o == '0) && (vel_first_o == '0))
  // the strobe ends the job
  `PLTI_ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o && !done_o)

endmodule

bind piecewise_linear_trajectory_interp_core plti_checker u_plti_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trajectory interpolator testbench
// Drives random clears, mostly ordered appends and queries into the core and checks
// every query result against a bit-accurate predictor of clamped piecewise
// linear position and one-second velocity, under both triple selections.
// ----------------------------------------------------------------------------
module testbench;
  import plti_pkg::*;

  localparam int unsigned DEPTH   = MAX_POINTS;
  localparam longint      MAX48   = 64'sh7FFF_FFFF_FFFF;
  localparam longint      MIN48   = -64'sh8000_0000_0000;
  localparam int          WDOG    = 5000;
  localparam logic [1:0]  KIND_SPARE = 2'd3;

  typedef struct {
    logic signed [47:0] pos [3];
    logic signed [47:0] vel [3];
    logic [1:0]         status;
  } fix_t;

  // Trajectory predictor: its own copy of the table and of use_ecef
  class traj_scoreboard;
    logic [31:0]        tab_time [DEPTH];
    logic signed [47:0] tab_crd  [DEPTH][6];
    int unsigned        count;
    bit                 dropped;
    bit                 ecef;
    fix_t               pending [$];
    int                 errors;
    int                 checked;

    function new();
      count = 0; dropped = 0; ecef = 1; errors = 0; checked = 0;
    endfunction

    // floor(alpha * d / 2^24)
    function longint scale(longint d, longint alpha);
      logic signed [127:0] prod;
      prod = 128'(d) * 128'(alpha);
      return longint'(prod >>> 24);
    endfunction

    function void locate(logic [32:0] t, output longint p [3]);
      int unsigned base, last, lo, hi, mid;
      longint t1, t2, alpha, p1, p2;
      base = ecef ? 0 : 3;
      last = count - 1;
      if (t <= {1'b0, tab_time[0]}) begin
        for (int k = 0; k < 3; k++) p[k] = tab_crd[0][base+k];
        return;
      end
      if (t >= {1'b0, tab_time[last]}) begin
        for (int k = 0; k < 3; k++) p[k] = tab_crd[last][base+k];
        return;
      end
      lo = 1; hi = last;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ({1'b0, tab_time[mid]} < t) lo = mid + 1;
        else hi = mid;
      end
      t1 = tab_time[lo-1];
      t2 = tab_time[lo];
      alpha = ((longint'(t) - t1) <<< 24) / (t2 - t1);
      for (int k = 0; k < 3; k++) begin
        p1 = tab_crd[lo-1][base+k];
        p2 = tab_crd[lo][base+k];
        p[k] = p1 + scale(p2 - p1, alpha);
      end
    endfunction

    // Note an accepted item and queue the result that it causes
    function void note_item(logic [1:0] kind, logic [31:0] pt,
                            logic signed [47:0] c [6], logic [31:0] qt);
      fix_t   r;
      longint p [3], q [3], d;
      case (kind)
        KIND_CLEAR: begin
          count = 0; dropped = 0;
        end
        KIND_APPEND: begin
          if (count >= DEPTH || (count > 0 && pt < tab_time[count-1])) dropped = 1;
          else begin
            tab_time[count] = pt;
            for (int k = 0; k < 6; k++) tab_crd[count][k] = c[k];
            count++;
          end
        end
        KIND_QUERY: begin
          for (int k = 0; k < 3; k++) begin r.pos[k] = 0; r.vel[k] = 0; end
          if (count == 0) r.status = STATUS_EMPTY;
          else begin
            locate({1'b0, qt}, p);
            for (int k = 0; k < 3; k++) r.pos[k] = p[k][47:0];
            if (count >= 2) begin
              locate({1'b0, qt} + ONE_SECOND, q);
              for (int k = 0; k < 3; k++) begin
                d = q[k] - p[k];
                if (d > MAX48) d = MAX48;
                if (d < MIN48) d = MIN48;
                r.vel[k] = d[47:0];
              end
            end
            r.status = dropped ? STATUS_DROPPED : STATUS_OK;
          end
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(fix_t got);
      fix_t e;
      bit   bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no query outstanding");
        return;
      end
      e = pending.pop_front();
      checked++;
      bad = (e.status !== got.status);
      for (int k = 0; k < 3; k++)
        bad |= (e.pos[k] !== got.pos[k]) || (e.vel[k] !== got.vel[k]);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch q%0d: exp pos %h %h %h vel %h %h %h st %0d / got pos %h %h %h vel %h %h %h st %0d",
                   checked, e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2],
                   e.status, got.pos[0], got.pos[1], got.pos[2], got.vel[0], got.vel[1],
                   got.vel[2], got.status);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0, cfg_we_i = 0, cfg_wdata_i = 0;
  logic busy_o, done_o;
  logic [1:0] kind_i = KIND_CLEAR, status_o;
  logic [31:0] point_time_i = 0, query_time_i = 0;
  logic signed [47:0] ecef_x_i = 0, ecef_y_i = 0, ecef_z_i = 0;
  logic signed [47:0] latitude_i = 0, longitude_i = 0, altitude_i = 0;
  logic signed [47:0] pos_first_o, pos_second_o, pos_third_o;
  logic signed [47:0] vel_first_o, vel_second_o, vel_third_o;

  traj_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  timed_out = 0;
  bit  calm = 0;
  int  queries = 0;
  logic [31:0] last_time = 0;

  always #5 clk_i = ~clk_i;

  piecewise_linear_trajectory_interp_core u_dut (.*);

  // Sample results at the rising edge; the receiver never stalls
  always @(posedge clk_i) begin
    fix_t got;
    if (rst_ni && done_o) begin
      got.pos[0] = pos_first_o; got.pos[1] = pos_second_o; got.pos[2] = pos_third_o;
      got.vel[0] = vel_first_o; got.vel[1] = vel_second_o; got.vel[2] = vel_third_o;
      got.status = status_o;
      sb.check_result(got);
    end
  end

  // Watchdog: count cycles with neither an item taken nor a result strobed
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("piecewise_linear_trajectory_interp_core verification failed");
      $finish;
    end
  end

  function automatic logic signed [47:0] rnd48();
    case ($urandom_range(0, 5))
      0: return 48'sh7FFF_FFFF_FFFF;
      1: return 48'sh8000_0000_0000;
      2: return 48'($signed($urandom_range(0, 2000)) - 1000);
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  // Hold off for a random burst now and then, except in the calm tail
  task automatic gap();
    if (!calm && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
  endtask

  // Present one item and hold it until it is taken
  task automatic send(logic [1:0] kind, logic [31:0] pt, logic signed [47:0] c [6],
                      logic [31:0] qt);
    kind_i = kind; point_time_i = pt; query_time_i = qt;
    ecef_x_i = c[0]; ecef_y_i = c[1]; ecef_z_i = c[2];
    latitude_i = c[3]; longitude_i = c[4]; altitude_i = c[5];
    start_i = 1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(kind, pt, c, qt);
    @(negedge clk_i);
    start_i = 0;
    if (kind == KIND_QUERY) queries++;
    gap();
  endtask

  task automatic append(logic [31:0] pt);
    logic signed [47:0] c [6];
    for (int k = 0; k < 6; k++) c[k] = rnd48();
    send(KIND_APPEND, pt, c, $urandom());
    last_time = pt;
  endtask

  task automatic query(logic [31:0] qt);
    logic signed [47:0] c [6];
    for (int k = 0; k < 6; k++) c[k] = rnd48();
    send(KIND_QUERY, $urandom(), c, qt);
  endtask

  task automatic clear();
    logic signed [47:0] c [6];
    for (int k = 0; k < 6; k++) c[k] = rnd48();
    send(KIND_CLEAR, $urandom(), c, $urandom());
    last_time = 0;
  endtask

  // Write the mode only once every query has answered
  task automatic set_mode(bit v);
    while (sb.pending.size() != 0 || busy_o) @(negedge clk_i);
    cfg_we_i = 1; cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.ecef = v;
  endtask

  // Pick a query time near or inside the current table span, or an extreme
  function automatic logic [31:0] pick_qt();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 0;
      2: return last_time + $urandom_range(0, 600) - 300;
      default: return $urandom_range(0, last_time + 512);
    endcase
  endfunction

  initial begin
    logic signed [47:0] zc [6];
    int items, n;
    for (int k = 0; k < 6; k++) zc[k] = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: empty table, single point, extremes, drops, spare kind
    query(32'h0);
    append(32'd1000);
    query(32'd0);
    query(32'hFFFF_FFFF);
    append(32'd500);                         // out of order, dropped
    append(32'd1000);                        // equal time accepted
    append(32'd1300);
    query(32'd1100);
    query(32'd1200);
    send(KIND_SPARE, 32'hFFFF_FFFF, zc, 32'hFFFF_FFFF);
    set_mode(0);
    query(32'd1100);
    clear();
    query(32'd5);
    begin
      logic signed [47:0] hi [6], lo [6];
      for (int k = 0; k < 6; k++) begin
        hi[k] = 48'sh7FFF_FFFF_FFFF; lo[k] = 48'sh8000_0000_0000;
      end
      send(KIND_APPEND, 32'd0, lo, 0);
      send(KIND_APPEND, 32'd256, hi, 0);
      send(KIND_APPEND, 32'd512, lo, 0);
      send(KIND_APPEND, 32'hFFFF_FFFF, hi, 0);
      last_time = 32'hFFFF_FFFF;
    end
    query(32'd0);                            // velocity saturates high
    query(32'd256);                          // velocity saturates low
    query(32'hFFFF_FF80);
    set_mode(1);
    query(32'd128);

    // Random: sessions of ordered appends then queries, with some noise
    items = 0;
    while (items < 1600) begin
      if (items > 1400) calm = 1;
      if ($urandom_range(0, 7) == 0) set_mode($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin clear(); items++; end
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1100) : $urandom_range(0, 12);
      if (n > 1600 - items) n = 1600 - items;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) append($urandom());
        else append(last_time + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000)));
        items++;
      end
      repeat ($urandom_range(2, 12)) begin query(pick_qt()); items++; end
      if ($urandom_range(0, 9) == 0) begin send(KIND_SPARE, $urandom(), zc, $urandom()); end
    end

    // Drain, then allow the latency of a last query
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("ran %0d items, checked %0d query results in both coordinate modes",
             items, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("piecewise_linear_trajectory_interp_core verification clean");
    else
      $display("piecewise_linear_trajectory_interp_core verification failed");
    $finish;
  end
endmodule
